// File: rtl/mexp_pkg.sv
package mexp_pkg;

	// Datapath width. The modulus, base and exponent are cut or zero-extended to it.
	localparam int WORD_WIDTH = 32;
	// Width of the fields on the ports.
	localparam int FIELD_W = 32;
	// Bit counter width, enough to index WORD_WIDTH bits.
	localparam int CNT_W = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DBL,
		ST_ADD,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_SQUARE,
		OP_MULT
	} op_t;

	typedef struct packed {
		logic load;
		logic start;
		logic dbl;
		logic add;
		logic commit;
		logic e_shift;
		logic publish;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic m_zero;
		logic e_msb;
		logic out_busy;
	} dp_status_t;

endpackage

// File: rtl/mexp_if.sv
interface mexp_operand_if import mexp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] base_value;
	logic [FIELD_W-1:0] exponent;

	modport source (output valid, output base_value, output exponent, input ready);
	modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_result_if import mexp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] power_residue;

	modport source (output valid, output power_residue, input ready);
	modport sink (input valid, input power_residue, output ready);
endinterface

// File: rtl/modular_exponentiation_core.sv
// Modular exponentiation core: each operand word carries a base and an exponent, and the
// core returns one result word holding base to the power exponent, reduced by the modulus
// register (reset value 1, written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the core is idle, as the core does not enforce this). The exponent is scanned
// from its most significant bit down; every step squares the running value, and a one bit
// then multiplies it by the base, which is reduced by the modulus first. Every product is
// formed exactly by a shift-and-add modular multiplier that handles each multiplier bit
// with a doubling and then a conditional add, each a single add-and-compare against the
// modulus, after a setup step for each product. A zero modulus is answered with a result
// of 0. A unit modulus gives 0 for every item, and a zero exponent gives 1 reduced by the
// modulus. The core works on one item at a time; the result sits in an output register, so
// a new operand word is taken as soon as the previous item's result has been registered,
// even while that result still waits.
module modular_exponentiation_core import mexp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [FIELD_W-1:0] cfg_wr_data,
	mexp_operand_if.sink       operand,
	mexp_result_if.source      result
);

	// Command and status groups between the sequencer and the arithmetic.
	dp_cmd_t    cmd;
	dp_status_t status;

	// The sequencer walks the exponent bits and the bits of each modular product.
	mexp_controller u_controller (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (operand.valid),
		.in_ready (operand.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the modulus, the operands, the running value and the result word.
	mexp_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.base_value    (operand.base_value),
		.exponent      (operand.exponent),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.power_residue (result.power_residue)
	);

endmodule

// File: rtl/mexp_datapath.sv
module mexp_datapath import mexp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [FIELD_W-1:0] cfg_wr_data,
	input  logic [FIELD_W-1:0] base_value,
	input  logic [FIELD_W-1:0] exponent,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [FIELD_W-1:0] power_residue
);

	localparam int W = WORD_WIDTH;

	logic [W-1:0] mod_q;
	logic [W-1:0] base_q;
	logic [W-1:0] b_q;
	logic [W-1:0] e_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] p_q;
	logic [W-1:0] x_q;
	logic [W-1:0] y_q;
	logic         out_valid_q;
	logic [W-1:0] out_data_q;

	logic [W-1:0] addend;
	logic [W:0]   sum;
	logic [W:0]   red;
	logic [W-1:0] p_next;
	logic [W-1:0] prod;
	logic [W-1:0] x_sel;
	logic [W-1:0] y_sel;

	// One modular add: both operands are below the modulus, so one subtract suffices.
	always_comb begin
		addend = cmd.dbl ? p_q : x_q;
		sum    = {1'b0, p_q} + {1'b0, addend};
		red    = (sum >= {1'b0, mod_q}) ? (sum - {1'b0, mod_q}) : sum;
		p_next = red[W-1:0];
		prod   = y_q[W-1] ? p_next : p_q;
	end

	always_comb begin
		case (cmd.op)
			OP_REDUCE: begin
				x_sel = W'(1);
				y_sel = base_q;
			end
			OP_SQUARE: begin
				x_sel = acc_q;
				y_sel = acc_q;
			end
			OP_MULT: begin
				x_sel = acc_q;
				y_sel = b_q;
			end
			default: begin
				x_sel = acc_q;
				y_sel = acc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= W'(1);
		end else if (cfg_wr_en) begin
			mod_q <= W'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= W'(base_value);
			e_q    <= W'(exponent);
			acc_q  <= (mod_q == W'(1)) ? '0 : W'(1);
		end
		if (cmd.start) begin
			p_q <= '0;
			x_q <= x_sel;
			y_q <= y_sel;
		end
		if (cmd.dbl) begin
			p_q <= p_next;
		end
		if (cmd.add) begin
			p_q <= prod;
			y_q <= y_q << 1;
		end
		if (cmd.commit) begin
			if (cmd.op == OP_REDUCE) begin
				b_q <= prod;
			end else begin
				acc_q <= prod;
			end
		end
		if (cmd.e_shift) begin
			e_q <= e_q << 1;
		end
		if (cmd.publish) begin
			out_data_q <= (mod_q == '0) ? '0 : acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.m_zero   = (mod_q == '0);
	assign status.e_msb    = e_q[W-1];
	assign status.out_busy = out_valid_q && !out_ready;

	assign out_valid     = out_valid_q;
	assign power_residue = FIELD_W'(out_data_q);

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !(out_valid_q && !out_ready))
		else $error("result word overwritten while still waiting");

	a_partial_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.add && mod_q != '0) |-> (p_q < mod_q))
		else $error("partial product not reduced below the modulus");

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && mod_q != '0) |-> (out_data_q < mod_q))
		else $error("result not below the modulus");

endmodule

// File: rtl/mexp_controller.sv
module mexp_controller import mexp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_WIDTH - 1);

	state_t           state_q, state_d;
	op_t              op_q, op_d;
	logic [CNT_W-1:0] bit_cnt_q, bit_cnt_d;
	logic [CNT_W-1:0] ecnt_q, ecnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_REDUCE;
			bit_cnt_q <= '0;
			ecnt_q    <= '0;
		end else begin
			state_q   <= state_d;
			op_q      <= op_d;
			bit_cnt_q <= bit_cnt_d;
			ecnt_q    <= ecnt_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		bit_cnt_d   = bit_cnt_q;
		ecnt_d      = ecnt_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.op      = op_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					op_d     = OP_REDUCE;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (status.m_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.start = 1'b1;
					bit_cnt_d = LAST_BIT;
					state_d   = ST_DBL;
				end
			end
			ST_DBL: begin
				cmd.dbl = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				if (bit_cnt_q != '0) begin
					bit_cnt_d = bit_cnt_q - CNT_W'(1);
					state_d   = ST_DBL;
				end else begin
					// The product is complete; decide the next operation.
					cmd.commit = 1'b1;
					state_d    = ST_START;
					if (op_q == OP_REDUCE) begin
						op_d   = OP_SQUARE;
						ecnt_d = LAST_BIT;
					end else if (op_q == OP_SQUARE && status.e_msb) begin
						op_d = OP_MULT;
					end else if (ecnt_q == '0) begin
						state_d = ST_FINISH;
					end else begin
						cmd.e_shift = 1'b1;
						ecnt_d      = ecnt_q - CNT_W'(1);
						op_d        = OP_SQUARE;
					end
				end
			end
			ST_FINISH: begin
				if (!status.out_busy) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_mul_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && bit_cnt_q != '0) |=> (state_q == ST_DBL))
		else $error("multiplier left before its last bit");

endmodule
